// File: design/dhsl_pkg.sv
// Package for the deadband heartbeat sample logger: widths, register map, reset values, types.
package dhsl_pkg;

  // Lane and field widths
  localparam int MAX_LANES    = 8;
  localparam int CHANNELS_DEF = 8;
  localparam int SAMPLE_W     = 10;
  localparam int LEVEL_W      = 12;
  localparam int COUNT_W      = 16;
  localparam int DEADBAND_W   = 12;
  localparam int GAIN_W       = 14;

  // Scaling: raw * gain / 1000, the divide done as a reciprocal multiply.
  // floor(x * RECIP / 2^34) equals floor(x / 1000) for every x below 2^24.
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int RECIP_W  = 25;
  localparam int WIDE_W   = PROD_W + RECIP_W;
  localparam int DIV_SHIFT = 34;
  localparam int QUOT_W   = WIDE_W - DIV_SHIFT;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 25'd17179870;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 12'd4095;

  // APB register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_ENABLE       = 3'd0;
  localparam logic [2:0] REG_MIN_INTERVAL = 3'd1;
  localparam logic [2:0] REG_MAX_INTERVAL = 3'd2;
  localparam logic [2:0] REG_DEADBAND     = 3'd3;
  localparam logic [2:0] REG_GAIN_MILLI   = 3'd4;

  // Reset values
  localparam logic                  RST_ENABLE       = 1'b1;
  localparam logic [COUNT_W-1:0]    RST_MIN_INTERVAL = 16'd60;
  localparam logic [COUNT_W-1:0]    RST_MAX_INTERVAL = 16'd180;
  localparam logic [DEADBAND_W-1:0] RST_DEADBAND     = 12'd3;
  localparam logic [GAIN_W-1:0]     RST_GAIN_MILLI   = 14'd3931;
  localparam logic [LEVEL_W-1:0]    RST_LAST_LOGGED  = 12'd255;

  typedef struct packed {
    logic                  enable;
    logic [COUNT_W-1:0]    min_interval;
    logic [COUNT_W-1:0]    max_interval;
    logic [DEADBAND_W-1:0] deadband;
    logic [GAIN_W-1:0]     gain_milli;
  } cfg_t;

  // Load strobes for the two lane stages
  typedef struct packed {
    logic ld1;
    logic ld2;
  } lane_ctl_t;

  typedef logic [MAX_LANES-1:0][LEVEL_W-1:0] level_vec_t;

endpackage

// File: design/dhsl_if.sv
// Stream interfaces: sample frames in, logged records out.
interface dhsl_sample_if;
  logic       valid;
  logic       ready;
  logic       second_tick;
  logic [9:0] sample_0;
  logic [9:0] sample_1;
  logic [9:0] sample_2;
  logic [9:0] sample_3;
  logic [9:0] sample_4;
  logic [9:0] sample_5;
  logic [9:0] sample_6;
  logic [9:0] sample_7;

  modport source (
    output valid, second_tick, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    input  ready
  );
  modport sink (
    input  valid, second_tick, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    output ready
  );
endinterface

interface dhsl_record_if;
  logic        valid;
  logic        ready;
  logic [11:0] level_0;
  logic [11:0] level_1;
  logic [11:0] level_2;
  logic [11:0] level_3;
  logic [11:0] level_4;
  logic [11:0] level_5;
  logic [11:0] level_6;
  logic [11:0] level_7;

  modport source (
    output valid, level_0, level_1, level_2, level_3, level_4, level_5,
           level_6, level_7,
    input  ready
  );
  modport sink (
    input  valid, level_0, level_1, level_2, level_3, level_4, level_5,
           level_6, level_7,
    output ready
  );
endinterface

// File: design/dhsl_cfg.sv
// APB register file holding the logger configuration.
module dhsl_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dhsl_pkg::ADDR_W-1:0]   paddr,
  input  logic [dhsl_pkg::DATA_W-1:0]   pwdata,
  output logic [dhsl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output dhsl_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= dhsl_pkg::RST_ENABLE;
      cfg.min_interval <= dhsl_pkg::RST_MIN_INTERVAL;
      cfg.max_interval <= dhsl_pkg::RST_MAX_INTERVAL;
      cfg.deadband     <= dhsl_pkg::RST_DEADBAND;
      cfg.gain_milli   <= dhsl_pkg::RST_GAIN_MILLI;
    end else if (wr_en) begin
      case (reg_idx)
        dhsl_pkg::REG_ENABLE:       cfg.enable       <= pwdata[0];
        dhsl_pkg::REG_MIN_INTERVAL: cfg.min_interval <= pwdata[15:0];
        dhsl_pkg::REG_MAX_INTERVAL: cfg.max_interval <= pwdata[15:0];
        dhsl_pkg::REG_DEADBAND:     cfg.deadband     <= pwdata[11:0];
        dhsl_pkg::REG_GAIN_MILLI:   cfg.gain_milli   <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (reg_idx)
      dhsl_pkg::REG_ENABLE:       prdata = {31'd0, cfg.enable};
      dhsl_pkg::REG_MIN_INTERVAL: prdata = {16'd0, cfg.min_interval};
      dhsl_pkg::REG_MAX_INTERVAL: prdata = {16'd0, cfg.max_interval};
      dhsl_pkg::REG_DEADBAND:     prdata = {20'd0, cfg.deadband};
      dhsl_pkg::REG_GAIN_MILLI:   prdata = {18'd0, cfg.gain_milli};
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: design/dhsl_lane.sv
// One channel lane: gain multiply, divide by 1000 via reciprocal, saturate.
module dhsl_lane (
  input  logic                            clk,
  input  dhsl_pkg::lane_ctl_t             ctl,
  input  logic [dhsl_pkg::SAMPLE_W-1:0]   sample,
  input  logic [dhsl_pkg::GAIN_W-1:0]     gain_milli,
  output logic [dhsl_pkg::LEVEL_W-1:0]    level
);

  logic [dhsl_pkg::PROD_W-1:0] prod;
  logic [dhsl_pkg::WIDE_W-1:0] wide;
  logic [dhsl_pkg::QUOT_W-1:0] quot;

  // Stage 1: raw * gain
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      prod <= dhsl_pkg::PROD_W'(sample) * dhsl_pkg::PROD_W'(gain_milli);
    end
  end

  // Stage 2: reciprocal multiply, then clamp to full scale
  assign wide = dhsl_pkg::WIDE_W'(prod) * dhsl_pkg::WIDE_W'(dhsl_pkg::DIV_RECIP);
  assign quot = wide[dhsl_pkg::WIDE_W-1:dhsl_pkg::DIV_SHIFT];

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      if (quot > dhsl_pkg::QUOT_W'(dhsl_pkg::LEVEL_MAX)) begin
        level <= dhsl_pkg::LEVEL_MAX;
      end else begin
        level <= quot[dhsl_pkg::LEVEL_W-1:0];
      end
    end
  end

endmodule

// File: design/dhsl_merge.sv
// Merge stage: interval counter, deadband check across lanes, record register.
module dhsl_merge #(
  parameter int CHANNELS = dhsl_pkg::CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dhsl_pkg::cfg_t         cfg,
  input  logic                   fire,
  input  dhsl_pkg::level_vec_t   levels,
  output logic                   out_free,
  dhsl_record_if.source          record
);

  logic [dhsl_pkg::COUNT_W-1:0] seconds_count;
  logic [dhsl_pkg::COUNT_W-1:0] count_inc;
  logic [dhsl_pkg::LEVEL_W-1:0] last_logged [CHANNELS];
  logic [CHANNELS-1:0]          lane_moved;
  logic                         force_rec;
  logic                         past_min;
  logic                         emit;
  logic                         out_valid;
  dhsl_pkg::level_vec_t         out_levels;

  // Per-lane deadband compare against the last logged value
  for (genvar i = 0; i < CHANNELS; i++) begin : g_cmp
    logic [dhsl_pkg::LEVEL_W-1:0] diff;
    assign diff = (levels[i] > last_logged[i]) ? levels[i] - last_logged[i]
                                               : last_logged[i] - levels[i];
    assign lane_moved[i] = (diff >= cfg.deadband);
  end

  // Record decision
  assign count_inc = seconds_count + 16'd1;
  assign force_rec = (count_inc >= cfg.max_interval);
  assign past_min  = (count_inc >= cfg.min_interval);
  assign emit      = force_rec | (past_min & (|lane_moved));
  assign out_free  = ~out_valid | record.ready;

  // Interval counter and logged values
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_logged[i] <= dhsl_pkg::RST_LAST_LOGGED;
      end
    end else if (fire) begin
      if (emit) begin
        seconds_count <= '0;
        for (int i = 0; i < CHANNELS; i++) begin
          last_logged[i] <= levels[i];
        end
      end else begin
        seconds_count <= count_inc;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (record.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_levels <= levels;
    end
  end

  assign record.valid   = out_valid;
  assign record.level_0 = out_levels[0];
  assign record.level_1 = out_levels[1];
  assign record.level_2 = out_levels[2];
  assign record.level_3 = out_levels[3];
  assign record.level_4 = out_levels[4];
  assign record.level_5 = out_levels[5];
  assign record.level_6 = out_levels[6];
  assign record.level_7 = out_levels[7];

  // Checks
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    fire && emit |=> seconds_count == '0)
    else $error("counter not cleared after record");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    fire && emit |=> record.valid)
    else $error("record not presented after emit");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    fire && !emit |=> seconds_count == 16'($past(seconds_count) + 16'd1))
    else $error("counter did not step by one");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(seconds_count))
    else $error("counter moved without an item");

endmodule

// File: design/deadband_heartbeat_sample_logger.sv
// Top level of the deadband heartbeat sample logger.
//
//   port       direction  kind        contents
//   samples    in         valid/ready second_tick, sample_0..sample_7
//   record     out        valid/ready level_0..level_7
//   p*         in/out     APB         enable, min/max interval, deadband, gain
//
// Throughput is one frame per cycle while samples.ready is high. A record passes
// the lane product register (loaded as its frame is taken), the lane level
// register, then the merge register before it can leave. The interval counter
// and logged values update in the merge loop as each frame fires, so
// consecutive frames see each other.
// Synchronous reset restores register defaults, clears the counter and sets
// every logged value to 255; no clearing pass is needed.
// A stalled record holds; the pipeline keeps taking frames until its stages
// are full, then samples.ready drops.
module deadband_heartbeat_sample_logger #(
  parameter int CHANNELS = dhsl_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  dhsl_sample_if.sink                   samples,
  dhsl_record_if.source                 record,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dhsl_pkg::ADDR_W-1:0]   paddr,
  input  logic [dhsl_pkg::DATA_W-1:0]   pwdata,
  output logic [dhsl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  dhsl_pkg::cfg_t       cfg;
  dhsl_pkg::lane_ctl_t  ctl;
  dhsl_pkg::level_vec_t levels;
  logic [dhsl_pkg::SAMPLE_W-1:0] sample_vec [dhsl_pkg::MAX_LANES];
  logic s1_valid;
  logic s2_valid;
  logic out_free;
  logic fire;

  dhsl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign sample_vec[0] = samples.sample_0;
  assign sample_vec[1] = samples.sample_1;
  assign sample_vec[2] = samples.sample_2;
  assign sample_vec[3] = samples.sample_3;
  assign sample_vec[4] = samples.sample_4;
  assign sample_vec[5] = samples.sample_5;
  assign sample_vec[6] = samples.sample_6;
  assign sample_vec[7] = samples.sample_7;

  // Pipeline advance: a stage loads when it is empty or moving on
  assign fire          = s2_valid & out_free;
  assign ctl.ld2       = ~s2_valid | fire;
  assign ctl.ld1       = ~s1_valid | ctl.ld2;
  assign samples.ready = ctl.ld1;

  // Only valid, ticking frames while enabled pass down the lanes as valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (ctl.ld1) begin
        s1_valid <= samples.valid & samples.second_tick & cfg.enable;
      end
      if (ctl.ld2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // Channel lanes; unused channels read as zero
  for (genvar i = 0; i < dhsl_pkg::MAX_LANES; i++) begin : g_lane
    if (i < CHANNELS) begin : g_used
      dhsl_lane u_lane (
        .clk        (clk),
        .ctl        (ctl),
        .sample     (sample_vec[i]),
        .gain_milli (cfg.gain_milli),
        .level      (levels[i])
      );
    end else begin : g_unused
      assign levels[i] = '0;
    end
  end

  dhsl_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fire     (fire),
    .levels   (levels),
    .out_free (out_free),
    .record   (record)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the deadband heartbeat sample logger.

// One sample frame as offered on the input stream
typedef struct packed {
  logic                                                   tick;
  logic [dhsl_pkg::MAX_LANES-1:0][dhsl_pkg::SAMPLE_W-1:0] raw;
} frame_t;

// Tracks the interval counter and logged levels, queues the records that are due
class logger_predictor;
  logic                            enable;
  logic [dhsl_pkg::COUNT_W-1:0]    min_iv;
  logic [dhsl_pkg::COUNT_W-1:0]    max_iv;
  logic [dhsl_pkg::DEADBAND_W-1:0] deadband;
  logic [dhsl_pkg::GAIN_W-1:0]     gain;
  logic [dhsl_pkg::COUNT_W-1:0]    seconds;
  dhsl_pkg::level_vec_t            logged;
  dhsl_pkg::level_vec_t            due_records[$];
  int unsigned                     errors;

  function new();
    enable   = dhsl_pkg::RST_ENABLE;
    min_iv   = dhsl_pkg::RST_MIN_INTERVAL;
    max_iv   = dhsl_pkg::RST_MAX_INTERVAL;
    deadband = dhsl_pkg::RST_DEADBAND;
    gain     = dhsl_pkg::RST_GAIN_MILLI;
    seconds  = '0;
    logged   = '0;
    for (int i = 0; i < dhsl_pkg::CHANNELS_DEF; i++) logged[i] = dhsl_pkg::RST_LAST_LOGGED;
    errors   = 0;
  endfunction

  function void flag(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      dhsl_pkg::REG_ENABLE:       enable   = value[0];
      dhsl_pkg::REG_MIN_INTERVAL: min_iv   = value[dhsl_pkg::COUNT_W-1:0];
      dhsl_pkg::REG_MAX_INTERVAL: max_iv   = value[dhsl_pkg::COUNT_W-1:0];
      dhsl_pkg::REG_DEADBAND:     deadband = value[dhsl_pkg::DEADBAND_W-1:0];
      dhsl_pkg::REG_GAIN_MILLI:   gain     = value[dhsl_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      dhsl_pkg::REG_ENABLE:       return 32'(enable);
      dhsl_pkg::REG_MIN_INTERVAL: return 32'(min_iv);
      dhsl_pkg::REG_MAX_INTERVAL: return 32'(max_iv);
      dhsl_pkg::REG_DEADBAND:     return 32'(deadband);
      dhsl_pkg::REG_GAIN_MILLI:   return 32'(gain);
      default:                    return '0;
    endcase
  endfunction

  // raw * gain / 1000, truncated, clipped at full scale
  function logic [dhsl_pkg::LEVEL_W-1:0] scale(logic [dhsl_pkg::SAMPLE_W-1:0] raw);
    int unsigned q;
    q = (32'(raw) * 32'(gain)) / 1000;
    return (q > 4095) ? dhsl_pkg::LEVEL_MAX : dhsl_pkg::LEVEL_W'(q);
  endfunction

  function void take_frame(frame_t f);
    dhsl_pkg::level_vec_t lv;
    bit                   emit;
    int unsigned          diff;
    if (!enable || !f.tick) return;
    seconds = seconds + dhsl_pkg::COUNT_W'(1);
    lv = '0;
    for (int i = 0; i < dhsl_pkg::CHANNELS_DEF; i++) lv[i] = scale(f.raw[i]);
    // below the heartbeat limit a record needs the minimum interval and a change
    if (seconds < max_iv) begin
      if (seconds < min_iv) return;
      emit = 0;
      for (int i = 0; i < dhsl_pkg::CHANNELS_DEF; i++) begin
        diff = (lv[i] > logged[i]) ? 32'(lv[i] - logged[i]) : 32'(logged[i] - lv[i]);
        if (diff >= 32'(deadband)) emit = 1;
      end
      if (!emit) return;
    end
    seconds = '0;
    for (int i = 0; i < dhsl_pkg::CHANNELS_DEF; i++) logged[i] = lv[i];
    due_records.push_back(lv);
  endfunction

  function void check_record(dhsl_pkg::level_vec_t got);
    dhsl_pkg::level_vec_t want;
    if (due_records.size() == 0) begin
      flag("record with none due", 0, 1);
      return;
    end
    want = due_records.pop_front();
    for (int i = 0; i < dhsl_pkg::MAX_LANES; i++)
      if (got[i] !== want[i])
        flag($sformatf("level_%0d", i), 32'(want[i]), 32'(got[i]));
  endfunction
endclass

module testbench;
  localparam int STEP_LATENCY    = 3;
  localparam int SETTLE_CYCLES   = STEP_LATENCY + 4;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int RANDOM_PHASES   = 9;
  localparam int PRESSURE_PHASE  = 6;
  localparam int LONG_RUN_FRAMES = 100;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [dhsl_pkg::ADDR_W-1:0] paddr;
  logic [dhsl_pkg::DATA_W-1:0] pwdata;
  logic [dhsl_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  dhsl_sample_if samples();
  dhsl_record_if record();

  logger_predictor      logger;
  int                   send_gap_pct;
  int                   recv_gap_pct;
  logic                 hold_records;
  int unsigned          quiet_cycles;
  dhsl_pkg::level_vec_t seen_levels;
  frame_t               last_frame;

  deadband_heartbeat_sample_logger DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .record  (record),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // record side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      record.ready <= 1'b0;
    end else begin
      record.ready <= !hold_records && ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // check every record transfer against the oldest due record
  always @(posedge clk) begin
    if (!rst && record.valid && record.ready) begin
      seen_levels[0] = record.level_0;
      seen_levels[1] = record.level_1;
      seen_levels[2] = record.level_2;
      seen_levels[3] = record.level_3;
      seen_levels[4] = record.level_4;
      seen_levels[5] = record.level_5;
      seen_levels[6] = record.level_6;
      seen_levels[7] = record.level_7;
      logger.check_record(seen_levels);
    end
  end

  // watchdog: too long without any transfer or register access
  always @(posedge clk) begin
    if (rst || psel || (samples.valid && samples.ready) || (record.valid && record.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic frame_t flat(int tick, logic [dhsl_pkg::SAMPLE_W-1:0] v);
    frame_t f;
    f.tick = (tick != 0);
    for (int i = 0; i < dhsl_pkg::MAX_LANES; i++) f.raw[i] = v;
    return f;
  endfunction

  // mostly slow drift from the previous frame, with jumps and rail values mixed in
  function automatic frame_t next_frame(frame_t prev, int tick_pct);
    frame_t f;
    int     v;
    f.tick = ($urandom_range(0, 99) < tick_pct);
    for (int i = 0; i < dhsl_pkg::MAX_LANES; i++) begin
      case ($urandom_range(0, 9))
        0: f.raw[i] = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        1, 2: f.raw[i] = 10'($urandom_range(0, 1023));
        default: begin
          v = int'(prev.raw[i]) + int'($urandom_range(0, 8)) - 4;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
          f.raw[i] = 10'(v);
        end
      endcase
    end
    return f;
  endfunction

  // random junk above the register's width, which the block must drop
  function automatic logic [31:0] dirty(logic [2:0] idx, logic [31:0] v);
    logic [31:0] keep;
    case (idx)
      dhsl_pkg::REG_ENABLE:       keep = 32'h1;
      dhsl_pkg::REG_MIN_INTERVAL: keep = 32'hFFFF;
      dhsl_pkg::REG_MAX_INTERVAL: keep = 32'hFFFF;
      dhsl_pkg::REG_DEADBAND:     keep = 32'hFFF;
      default:                    keep = 32'h3FFF;
    endcase
    return (v & keep) | ($urandom & ~keep);
  endfunction

  task automatic send_frame(frame_t f);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid       <= 1'b1;
    samples.second_tick <= f.tick;
    samples.sample_0    <= f.raw[0];
    samples.sample_1    <= f.raw[1];
    samples.sample_2    <= f.raw[2];
    samples.sample_3    <= f.raw[3];
    samples.sample_4    <= f.raw[4];
    samples.sample_5    <= f.raw[5];
    samples.sample_6    <= f.raw[6];
    samples.sample_7    <= f.raw[7];
    do @(posedge clk); while (!samples.ready);
    logger.take_frame(f);
  endtask

  task automatic stop_frames();
    samples.valid <= 1'b0;
  endtask

  // wait for every due record, then for frames that leave no record
  task automatic settle();
    while (logger.due_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_check(logic [2:0] idx);
    logic [dhsl_pkg::DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== logger.reg_value(idx))
      logger.flag($sformatf("register %0d read", idx), logger.reg_value(idx), rd);
    @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    logger.write_reg(idx, value);
    @(posedge clk);
    if (idx <= dhsl_pkg::REG_GAIN_MILLI) cfg_check(idx);
  endtask

  initial begin
    frame_t f;
    int     ph;
    int     n;
    int     tick_pct;
    logger              = new();
    clk                 = 1'b0;
    rst                 = 1'b1;
    hold_records        = 1'b0;
    quiet_cycles        = 0;
    send_gap_pct        = 0;
    recv_gap_pct        = 0;
    last_frame          = flat(0, 10'd512);
    samples.valid       = 1'b0;
    samples.second_tick = 1'b0;
    samples.sample_0    = '0;
    samples.sample_1    = '0;
    samples.sample_2    = '0;
    samples.sample_3    = '0;
    samples.sample_4    = '0;
    samples.sample_5    = '0;
    samples.sample_6    = '0;
    samples.sample_7    = '0;
    record.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults after reset
    for (int k = dhsl_pkg::REG_ENABLE; k <= dhsl_pkg::REG_GAIN_MILLI; k++) cfg_check(3'(k));

    // default intervals: ticks and idle frames, none far enough for a record
    send_frame(flat(0, 10'h3FF));
    send_frame(flat(1, 10'h000));
    send_frame(flat(1, 10'h3FF));
    stop_frames();
    settle();

    // zero max interval: every tick logs
    cfg_write(dhsl_pkg::REG_MIN_INTERVAL, 0);
    cfg_write(dhsl_pkg::REG_MAX_INTERVAL, 0);
    send_frame(flat(1, 10'h3FF));
    send_frame(flat(1, 10'h000));
    send_frame(flat(0, 10'h3FF));
    stop_frames();
    settle();

    // full gain: saturation and the edge around it
    cfg_write(dhsl_pkg::REG_GAIN_MILLI, 16383);
    send_frame(flat(1, 10'h3FF));
    f = flat(1, 10'd0);
    f.raw = {10'd1, 10'h2AA, 10'h155, 10'd512, 10'd250, 10'd245, 10'd244, 10'd1};
    send_frame(f);
    stop_frames();
    settle();

    // zero gain
    cfg_write(dhsl_pkg::REG_GAIN_MILLI, 0);
    send_frame(flat(1, 10'h3FF));
    stop_frames();
    settle();

    // disabled: ticks ignored
    cfg_write(dhsl_pkg::REG_ENABLE, 0);
    send_frame(flat(1, 10'h3FF));
    send_frame(flat(1, 10'h000));
    stop_frames();
    settle();

    // zero deadband: unchanged levels still log
    cfg_write(dhsl_pkg::REG_ENABLE, 1);
    cfg_write(dhsl_pkg::REG_GAIN_MILLI, 1000);
    cfg_write(dhsl_pkg::REG_MAX_INTERVAL, 32'hFFFF);
    cfg_write(dhsl_pkg::REG_DEADBAND, 0);
    send_frame(flat(1, 10'd5));
    send_frame(flat(1, 10'd5));
    send_frame(flat(1, 10'd0));
    stop_frames();
    settle();

    // widest deadband: only a full-scale swing logs
    cfg_write(dhsl_pkg::REG_DEADBAND, 4095);
    cfg_write(dhsl_pkg::REG_GAIN_MILLI, 16383);
    send_frame(flat(1, 10'd0));
    f = flat(1, 10'd0);
    f.raw[3] = 10'h3FF;
    send_frame(f);
    send_frame(flat(1, 10'd0));
    stop_frames();
    settle();

    // change right at the deadband, then below it until the heartbeat forces one
    cfg_write(dhsl_pkg::REG_DEADBAND, 2);
    cfg_write(dhsl_pkg::REG_MIN_INTERVAL, 3);
    cfg_write(dhsl_pkg::REG_MAX_INTERVAL, 5);
    cfg_write(dhsl_pkg::REG_GAIN_MILLI, 1000);
    send_frame(flat(1, 10'd0));
    send_frame(flat(1, 10'd0));
    f = flat(1, 10'd0);
    f.raw[0] = 10'd2;
    send_frame(f);
    f.raw[0] = 10'd3;
    repeat (5) send_frame(f);
    stop_frames();
    settle();

    // writes past the register list change nothing
    for (int k = dhsl_pkg::REG_GAIN_MILLI + 1; k < 8; k++) cfg_write(3'(k), '1);
    for (int k = dhsl_pkg::REG_ENABLE; k <= dhsl_pkg::REG_GAIN_MILLI; k++) cfg_check(3'(k));

    // random phases: receiver idles more, then sender idles more, then neither
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_gap_pct = (ph < 3) ? 19 : (ph < 6) ? 49 : 0;
      recv_gap_pct = (ph < 3) ? 49 : (ph < 6) ? 19 : 0;
      stop_frames();
      settle();
      if (ph == 0) begin
        cfg_write(dhsl_pkg::REG_ENABLE, 32'(dhsl_pkg::RST_ENABLE));
        cfg_write(dhsl_pkg::REG_MIN_INTERVAL, 32'(dhsl_pkg::RST_MIN_INTERVAL));
        cfg_write(dhsl_pkg::REG_MAX_INTERVAL, 32'(dhsl_pkg::RST_MAX_INTERVAL));
        cfg_write(dhsl_pkg::REG_DEADBAND, 32'(dhsl_pkg::RST_DEADBAND));
        cfg_write(dhsl_pkg::REG_GAIN_MILLI, 32'(dhsl_pkg::RST_GAIN_MILLI));
        n = 260;
        tick_pct = 100;
      end else begin
        if ($urandom_range(0, 3) != 0)
          cfg_write(dhsl_pkg::REG_ENABLE,
            dirty(dhsl_pkg::REG_ENABLE, 32'($urandom_range(0, 5) != 0)));
        if ($urandom_range(0, 3) != 0)
          cfg_write(dhsl_pkg::REG_MIN_INTERVAL, dirty(dhsl_pkg::REG_MIN_INTERVAL,
            ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 8)));
        if ($urandom_range(0, 3) != 0)
          cfg_write(dhsl_pkg::REG_MAX_INTERVAL, dirty(dhsl_pkg::REG_MAX_INTERVAL,
            ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 14)));
        if ($urandom_range(0, 3) != 0)
          case ($urandom_range(0, 4))
            0: cfg_write(dhsl_pkg::REG_DEADBAND, dirty(dhsl_pkg::REG_DEADBAND, 0));
            1: cfg_write(dhsl_pkg::REG_DEADBAND, dirty(dhsl_pkg::REG_DEADBAND, 4095));
            2: cfg_write(dhsl_pkg::REG_DEADBAND,
                 dirty(dhsl_pkg::REG_DEADBAND, $urandom_range(0, 4095)));
            default: cfg_write(dhsl_pkg::REG_DEADBAND,
                       dirty(dhsl_pkg::REG_DEADBAND, $urandom_range(1, 40)));
          endcase
        if ($urandom_range(0, 3) != 0)
          case ($urandom_range(0, 5))
            0: cfg_write(dhsl_pkg::REG_GAIN_MILLI, dirty(dhsl_pkg::REG_GAIN_MILLI, 0));
            1: cfg_write(dhsl_pkg::REG_GAIN_MILLI, dirty(dhsl_pkg::REG_GAIN_MILLI, 16383));
            2: cfg_write(dhsl_pkg::REG_GAIN_MILLI,
                 dirty(dhsl_pkg::REG_GAIN_MILLI, $urandom_range(0, 16383)));
            default: cfg_write(dhsl_pkg::REG_GAIN_MILLI,
                       dirty(dhsl_pkg::REG_GAIN_MILLI, $urandom_range(500, 4000)));
          endcase
        if ($urandom_range(0, 4) == 0)
          cfg_write(3'(dhsl_pkg::REG_GAIN_MILLI + 1 + $urandom_range(0, 2)), $urandom);
        n = 120;
        tick_pct = $urandom_range(60, 100);
      end
      // receiver holds off while every tick logs, so the pipeline backs up
      if (ph == PRESSURE_PHASE) begin
        cfg_write(dhsl_pkg::REG_ENABLE, 1);
        cfg_write(dhsl_pkg::REG_MIN_INTERVAL, 0);
        cfg_write(dhsl_pkg::REG_MAX_INTERVAL, 0);
        tick_pct = 100;
        fork
          begin
            hold_records <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge clk);
            hold_records <= 1'b0;
          end
        join_none
      end
      repeat (n) begin
        last_frame = next_frame(last_frame, tick_pct);
        send_frame(last_frame);
      end
    end

    // minimum above maximum with the widest deadband: only the heartbeat logs
    stop_frames();
    settle();
    cfg_write(dhsl_pkg::REG_ENABLE, 1);
    cfg_write(dhsl_pkg::REG_MIN_INTERVAL, 32'hFFFF);
    cfg_write(dhsl_pkg::REG_MAX_INTERVAL, 97);
    cfg_write(dhsl_pkg::REG_DEADBAND, 4095);
    cfg_write(dhsl_pkg::REG_GAIN_MILLI, 0);
    repeat (LONG_RUN_FRAMES) begin
      last_frame = next_frame(last_frame, 100);
      send_frame(last_frame);
    end

    stop_frames();
    settle();
    if (logger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
